### hw/rtl/extended_gcd_assert.svh
// Assertion macros used by the extended gcd RTL.
`ifndef EXTENDED_GCD_ASSERT_SVH
`define EXTENDED_GCD_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define EGCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("extended_gcd assertion failed");

// Next-cycle implication, checked outside reset.
`define EGCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("extended_gcd assertion failed");

`endif

### hw/rtl/egcd_pkg.sv
`timescale 1ns / 1ps

package egcd_pkg;

    localparam int OPND_W   = 31;
    localparam int COEF_W   = 32;
    // Coefficients and products need two bits above the output width.
    localparam int ACC_W    = COEF_W + 2;
    localparam int CNT_W    = $clog2(OPND_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(OPND_W - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_UPD   = 4'b1000
    } t_state;

endpackage

### hw/rtl/extended_gcd.sv
`timescale 1ns / 1ps

// Extended Euclid: returns gcd(a, b) and coefficients with a*coef_a + b*coef_b = gcd.
// A request is taken when start is high and busy is low; the result shows for one
// cycle on o_result_valid and must be captured then, since the receiver cannot stall.
// Each Euclid step is a zero test, a pass of the shared bit-serial restoring divider
// and one coefficient update; 31-bit operands need up to 45 steps. The divider also
// forms quotient*coefficient by shift-and-add, one quotient bit per cycle. busy is
// high from the request until the result is issued.
module extended_gcd (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [egcd_pkg::OPND_W-1:0]         i_operand_a,
    input  logic [egcd_pkg::OPND_W-1:0]         i_operand_b,
    output logic                                o_result_valid,
    output logic [egcd_pkg::OPND_W-1:0]         o_gcd_value,
    output logic signed [egcd_pkg::COEF_W-1:0]  o_coef_a,
    output logic signed [egcd_pkg::COEF_W-1:0]  o_coef_b
);

`include "extended_gcd_assert.svh"

    egcd_pkg::t_state r_state, n_state;

    logic [egcd_pkg::OPND_W-1:0]        r_prev_rem, n_prev_rem;
    logic [egcd_pkg::OPND_W-1:0]        r_cur_rem, n_cur_rem;
    logic signed [egcd_pkg::ACC_W-1:0]  r_prev_x, n_prev_x;
    logic signed [egcd_pkg::ACC_W-1:0]  r_cur_x, n_cur_x;
    logic signed [egcd_pkg::ACC_W-1:0]  r_prev_y, n_prev_y;
    logic signed [egcd_pkg::ACC_W-1:0]  r_cur_y, n_cur_y;
    logic signed [egcd_pkg::ACC_W-1:0]  r_acc_x, n_acc_x;
    logic signed [egcd_pkg::ACC_W-1:0]  r_acc_y, n_acc_y;
    logic [egcd_pkg::OPND_W-1:0]        r_div_rem, n_div_rem;
    logic [egcd_pkg::OPND_W-1:0]        r_div_num, n_div_num;
    logic [egcd_pkg::CNT_W-1:0]         r_div_cnt, n_div_cnt;

    logic                               r_valid, n_valid;
    logic [egcd_pkg::OPND_W-1:0]        r_gcd, n_gcd;
    logic signed [egcd_pkg::COEF_W-1:0] r_coef_a, n_coef_a;
    logic signed [egcd_pkg::COEF_W-1:0] r_coef_b, n_coef_b;

    logic [egcd_pkg::OPND_W:0]          w_part;
    logic [egcd_pkg::OPND_W:0]          w_diff;
    logic                               w_ge;

    // One restoring-division step: bring down the next dividend bit and try a subtract.
    assign w_part = {r_div_rem, r_div_num[egcd_pkg::OPND_W-1]};
    assign w_diff = w_part - {1'b0, r_cur_rem};
    assign w_ge   = (w_part >= {1'b0, r_cur_rem});

    always_comb begin
        n_state    = r_state;
        n_prev_rem = r_prev_rem;
        n_cur_rem  = r_cur_rem;
        n_prev_x   = r_prev_x;
        n_cur_x    = r_cur_x;
        n_prev_y   = r_prev_y;
        n_cur_y    = r_cur_y;
        n_acc_x    = r_acc_x;
        n_acc_y    = r_acc_y;
        n_div_rem  = r_div_rem;
        n_div_num  = r_div_num;
        n_div_cnt  = r_div_cnt;
        n_valid    = 1'b0;
        n_gcd      = r_gcd;
        n_coef_a   = r_coef_a;
        n_coef_b   = r_coef_b;

        case (r_state)
            egcd_pkg::S_IDLE: begin
                if (start) begin
                    n_prev_rem = i_operand_a;
                    n_cur_rem  = i_operand_b;
                    n_prev_x   = egcd_pkg::ACC_W'(1);
                    n_cur_x    = '0;
                    n_prev_y   = '0;
                    n_cur_y    = egcd_pkg::ACC_W'(1);
                    n_state    = egcd_pkg::S_CHECK;
                end
            end
            egcd_pkg::S_CHECK: begin
                if (r_cur_rem == '0) begin
                    n_valid  = 1'b1;
                    n_gcd    = r_prev_rem;
                    n_coef_a = r_prev_x[egcd_pkg::COEF_W-1:0];
                    n_coef_b = r_prev_y[egcd_pkg::COEF_W-1:0];
                    n_state  = egcd_pkg::S_IDLE;
                end else begin
                    n_div_rem = '0;
                    n_div_num = r_prev_rem;
                    n_div_cnt = '0;
                    n_acc_x   = '0;
                    n_acc_y   = '0;
                    n_state   = egcd_pkg::S_DIV;
                end
            end
            egcd_pkg::S_DIV: begin
                n_div_rem = w_ge ? w_diff[egcd_pkg::OPND_W-1:0]
                                 : w_part[egcd_pkg::OPND_W-1:0];
                n_div_num = {r_div_num[egcd_pkg::OPND_W-2:0], 1'b0};
                // Horner form of quotient times the current coefficients, MSB first.
                n_acc_x   = (r_acc_x <<< 1) + (w_ge ? r_cur_x : '0);
                n_acc_y   = (r_acc_y <<< 1) + (w_ge ? r_cur_y : '0);
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == egcd_pkg::DIV_LAST) begin
                    n_state = egcd_pkg::S_UPD;
                end
            end
            egcd_pkg::S_UPD: begin
                n_prev_rem = r_cur_rem;
                n_cur_rem  = r_div_rem;
                n_prev_x   = r_cur_x;
                n_cur_x    = r_prev_x - r_acc_x;
                n_prev_y   = r_cur_y;
                n_cur_y    = r_prev_y - r_acc_y;
                n_state    = egcd_pkg::S_CHECK;
            end
            default: begin
                n_state = egcd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= egcd_pkg::S_IDLE;
            r_valid   <= 1'b0;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev_rem <= n_prev_rem;
        r_cur_rem  <= n_cur_rem;
        r_prev_x   <= n_prev_x;
        r_cur_x    <= n_cur_x;
        r_prev_y   <= n_prev_y;
        r_cur_y    <= n_cur_y;
        r_acc_x    <= n_acc_x;
        r_acc_y    <= n_acc_y;
        r_div_rem  <= n_div_rem;
        r_div_num  <= n_div_num;
        r_gcd      <= n_gcd;
        r_coef_a   <= n_coef_a;
        r_coef_b   <= n_coef_b;
    end

    assign busy           = (r_state != egcd_pkg::S_IDLE);
    assign o_result_valid = r_valid;
    assign o_gcd_value    = r_gcd;
    assign o_coef_a       = r_coef_a;
    assign o_coef_b       = r_coef_b;

    `EGCD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `EGCD_ASSERT_NOW(a_result_idle, o_result_valid, !busy)
    `EGCD_ASSERT_NOW(a_result_from_check, o_result_valid, $past(r_state) == egcd_pkg::S_CHECK)
    `EGCD_ASSERT_NEXT(a_div_end, (r_state == egcd_pkg::S_DIV) && (r_div_cnt == egcd_pkg::DIV_LAST), r_state == egcd_pkg::S_UPD)
    `EGCD_ASSERT_NOW(a_rem_below_divisor, r_state == egcd_pkg::S_UPD, r_div_rem < r_cur_rem)

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int N_RANDOM   = 352;
    localparam int N_PHASES   = 4;
    localparam int N_DIRECTED = 18;
    localparam int LIMIT      = 4_000_000;
    localparam int SETTLE     = 64;

    localparam logic [egcd_pkg::OPND_W-1:0] OPND_MAX = '1;

    // Sender idle percentage for each stretch of the random part.
    localparam int PHASE_IDLE [N_PHASES] = '{0, 54, 0, 34};

    typedef struct packed {
        logic [egcd_pkg::OPND_W-1:0]        gcd;
        logic signed [egcd_pkg::COEF_W-1:0] coef_a;
        logic signed [egcd_pkg::COEF_W-1:0] coef_b;
    } t_bezout;

    typedef struct packed {
        logic [egcd_pkg::OPND_W-1:0] a;
        logic [egcd_pkg::OPND_W-1:0] b;
        logic                        known;
        t_bezout                     res;
    } t_gcd_row;

    typedef enum int {
        K_FULL,
        K_SMALL,
        K_FACTOR,
        K_ZERO,
        K_FIB,
        K_MULTIPLE,
        K_PATTERN
    } t_operand_kind;

    // Rows marked known carry a result that is obvious from the algorithm;
    // the rest are checked against the predictor.
    t_gcd_row dir_rows [N_DIRECTED] = '{
        '{31'd0,         31'd0,         1'b1, '{31'd0,    32'sd1, 32'sd0}},
        '{OPND_MAX,      31'd0,         1'b1, '{OPND_MAX, 32'sd1, 32'sd0}},
        '{31'd0,         OPND_MAX,      1'b1, '{OPND_MAX, 32'sd0, 32'sd1}},
        '{31'd0,         31'd1,         1'b1, '{31'd1,    32'sd0, 32'sd1}},
        '{31'd1,         31'd0,         1'b1, '{31'd1,    32'sd1, 32'sd0}},
        '{31'd1,         31'd1,         1'b1, '{31'd1,    32'sd0, 32'sd1}},
        '{OPND_MAX,      OPND_MAX,      1'b1, '{OPND_MAX, 32'sd0, 32'sd1}},
        '{OPND_MAX,      31'd1,         1'b1, '{31'd1,    32'sd0, 32'sd1}},
        '{31'd1,         OPND_MAX,      1'b0, '0},
        '{OPND_MAX,      OPND_MAX - 1,  1'b0, '0},
        '{31'd1836311903, 31'd1134903170, 1'b0, '0},
        '{31'd1134903170, 31'd1836311903, 1'b0, '0},
        '{31'h40000000,  31'h20000000,  1'b0, '0},
        '{31'h55555555,  31'h2AAAAAAA,  1'b0, '0},
        '{31'h2AAAAAAA,  31'h55555555,  1'b0, '0},
        '{31'd1000000007, 31'd998244353, 1'b0, '0},
        '{31'd12,        31'd18,        1'b0, '0},
        '{OPND_MAX,      31'h40000000,  1'b0, '0}
    };

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    logic [egcd_pkg::OPND_W-1:0]        i_operand_a = '0;
    logic [egcd_pkg::OPND_W-1:0]        i_operand_b = '0;
    logic                               o_result_valid;
    logic [egcd_pkg::OPND_W-1:0]        o_gcd_value;
    logic signed [egcd_pkg::COEF_W-1:0] o_coef_a;
    logic signed [egcd_pkg::COEF_W-1:0] o_coef_b;

    t_bezout pending_results [$];
    int      n_errors = 0;
    int      cycle_count = 0;
    int      idle_pct = 0;

    extended_gcd i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .o_result_valid (o_result_valid),
        .o_gcd_value    (o_gcd_value),
        .o_coef_a       (o_coef_a),
        .o_coef_b       (o_coef_b)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Euclid with exact 64-bit coefficients, truncated to the port widths at the end.
    function automatic t_bezout solve_bezout(input logic [egcd_pkg::OPND_W-1:0] a,
                                             input logic [egcd_pkg::OPND_W-1:0] b);
        longint unsigned r0, r1, q, r;
        longint          x0, x1, y0, y1, nx, ny;
        t_bezout         res;
        r0 = 64'(a);
        r1 = 64'(b);
        x0 = 1;
        x1 = 0;
        y0 = 0;
        y1 = 1;
        while (r1 != 0) begin
            q  = r0 / r1;
            r  = r0 % r1;
            nx = x0 - $signed(q) * x1;
            ny = y0 - $signed(q) * y1;
            r0 = r1;
            r1 = r;
            x0 = x1;
            x1 = nx;
            y0 = y1;
            y1 = ny;
        end
        res.gcd    = r0[egcd_pkg::OPND_W-1:0];
        res.coef_a = x0[egcd_pkg::COEF_W-1:0];
        res.coef_b = y0[egcd_pkg::COEF_W-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string what,
                                 input logic [egcd_pkg::COEF_W-1:0] got,
                                 input logic [egcd_pkg::COEF_W-1:0] want);
        n_errors++;
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got,
                 want);
    endtask

    // Presents one request, holding start until it is taken. Operands carry noise
    // while the sender idles.
    task automatic issue_request(input logic [egcd_pkg::OPND_W-1:0] a,
                                 input logic [egcd_pkg::OPND_W-1:0] b,
                                 input logic known, input t_bezout known_res);
        t_bezout want_res;
        while ($urandom_range(99) < idle_pct) begin
            start       <= 1'b0;
            i_operand_a <= egcd_pkg::OPND_W'($urandom);
            i_operand_b <= egcd_pkg::OPND_W'($urandom);
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        want_res = known ? known_res : solve_bezout(a, b);
        pending_results.insert(pending_results.size(), want_res);
    endtask

    always @(posedge i_clk) begin
        t_bezout exp_res;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result with no request pending", {1'b0, o_gcd_value}, '0);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_gcd_value !== exp_res.gcd)
                    flag_mismatch("gcd_value", {1'b0, o_gcd_value}, {1'b0, exp_res.gcd});
                if (o_coef_a !== exp_res.coef_a)
                    flag_mismatch("coef_a", o_coef_a, exp_res.coef_a);
                if (o_coef_b !== exp_res.coef_b)
                    flag_mismatch("coef_b", o_coef_b, exp_res.coef_b);
            end
        end
    end

    initial begin
        logic [egcd_pkg::OPND_W-1:0] a, b, t;
        t_operand_kind               kind;
        int unsigned                 pick, g, f0, f1, fn;
        int                          n;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            issue_request(dir_rows[i].a, dir_rows[i].b, dir_rows[i].known, dir_rows[i].res);

        for (int i = 0; i < N_RANDOM; i++) begin
            idle_pct = PHASE_IDLE[(i * N_PHASES) / N_RANDOM];
            pick = $urandom_range(99);
            if (pick < 30)      kind = K_FULL;
            else if (pick < 45) kind = K_SMALL;
            else if (pick < 62) kind = K_FACTOR;
            else if (pick < 70) kind = K_ZERO;
            else if (pick < 75) kind = K_FIB;
            else if (pick < 85) kind = K_MULTIPLE;
            else                kind = K_PATTERN;

            case (kind)
                K_FULL: begin
                    a = egcd_pkg::OPND_W'($urandom);
                    b = egcd_pkg::OPND_W'($urandom);
                end
                K_SMALL: begin
                    a = egcd_pkg::OPND_W'($urandom_range(0, 255));
                    b = egcd_pkg::OPND_W'($urandom_range(0, 255));
                end
                K_FACTOR: begin
                    g = $urandom_range(1, 65535);
                    a = egcd_pkg::OPND_W'(g * $urandom_range(0, 32767));
                    b = egcd_pkg::OPND_W'(g * $urandom_range(0, 32767));
                end
                K_ZERO: begin
                    a = egcd_pkg::OPND_W'($urandom);
                    b = '0;
                end
                K_FIB: begin
                    // Consecutive Fibonacci numbers need the most division steps.
                    n  = $urandom_range(2, 45);
                    f0 = 0;
                    f1 = 1;
                    for (int k = 0; k < n; k++) begin
                        fn = f0 + f1;
                        f0 = f1;
                        f1 = fn;
                    end
                    a = egcd_pkg::OPND_W'(f1);
                    b = egcd_pkg::OPND_W'(f0);
                end
                K_MULTIPLE: begin
                    b = egcd_pkg::OPND_W'($urandom);
                    a = egcd_pkg::OPND_W'(b * $urandom_range(0, 3));
                end
                default: begin
                    a = egcd_pkg::OPND_W'(1) << $urandom_range(0, egcd_pkg::OPND_W - 1);
                    b = OPND_MAX >> $urandom_range(0, egcd_pkg::OPND_W - 1);
                end
            endcase

            if ($urandom_range(1)) begin
                t = a;
                a = b;
                b = t;
            end
            issue_request(a, b, 1'b0, '0);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/egcd_pkg.sv
hw/rtl/extended_gcd.sv
dv/tb.sv
